// ===== rtl/sic_pkg.sv =====
// Package for the segment intersection core.
// Holds the field widths, pipeline lengths, shared types and the output saturation functions.
// No dependencies.
package sic_pkg;

   localparam int COORD_W  = 16;
   localparam int FRAC_W   = 16;
   localparam int PARAM_W  = 32;

   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int H_W      = PROD_W + 1;
   localparam int DEN_W    = H_W;
   localparam int N1_W     = H_W + 1;
   localparam int EXT_W    = (DIFF_W > FRAC_W) ? DIFF_W : FRAC_W;
   localparam int NUM_W    = N1_W + EXT_W + 1;
   localparam int QB       = PARAM_W + 1;
   localparam int CMP_W    = DEN_W + QB + 1;

   localparam int FRONT_LAT = 6;
   localparam int DIV_LAT   = QB + 2;
   localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [N1_W-1:0]    n1_type;
   typedef logic        [DEN_W-1:0]   den_type;
   typedef logic signed [NUM_W-1:0]   num_type;
   typedef logic        [QB:0]        quot_type;

   typedef struct packed {
      logic hit;
      logic parallel;
   } flags_type;

   localparam quot_type COORD_MAX = quot_type'((64'd1 << (COORD_W - 1)) - 64'd1);
   localparam quot_type PARAM_MAX = quot_type'((64'd1 << (PARAM_W - 1)) - 64'd1);

   function automatic logic [COORD_W-1:0] sat_coord(input quot_type q, input logic neg);
      quot_type lim;
      quot_type mag;
      quot_type val;
      lim = neg ? COORD_MAX + quot_type'(1) : COORD_MAX;
      mag = (q > lim) ? lim : q;
      val = neg ? (~mag + quot_type'(1)) : mag;
      return val[COORD_W-1:0];
   endfunction

   function automatic logic [PARAM_W-1:0] sat_param(input quot_type q, input logic neg);
      quot_type lim;
      quot_type mag;
      quot_type val;
      lim = neg ? PARAM_MAX + quot_type'(1) : PARAM_MAX;
      mag = (q > lim) ? lim : q;
      val = neg ? (~mag + quot_type'(1)) : mag;
      return val[PARAM_W-1:0];
   endfunction

endpackage

// ===== rtl/sic_front.sv =====
// Front pipeline of the segment intersection core: differences, cross products,
// sign normalization, hit test and dividend forming over six register stages.
// Depends on sic_pkg.
module sic_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sic_pkg::coord_type  lsx,
   input  sic_pkg::coord_type  lsy,
   input  sic_pkg::coord_type  lex,
   input  sic_pkg::coord_type  ley,
   input  sic_pkg::coord_type  rsx,
   input  sic_pkg::coord_type  rsy,
   input  sic_pkg::coord_type  rex,
   input  sic_pkg::coord_type  rey,
   output logic                out_valid,
   output sic_pkg::flags_type  out_flags,
   output sic_pkg::num_type    num_x,
   output sic_pkg::num_type    num_y,
   output sic_pkg::num_type    num_t,
   output sic_pkg::den_type    den
);

   logic [sic_pkg::FRONT_LAT-1:0] valid_ff;

   sic_pkg::diff_type a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff;
   sic_pkg::diff_type kx1_ff, ky1_ff, kx2_ff, ky2_ff, kx3_ff, ky3_ff, kx4_ff, ky4_ff;
   sic_pkg::coord_type lsx1_ff, lsy1_ff, lsx2_ff, lsy2_ff, lsx3_ff, lsy3_ff, lsx4_ff, lsy4_ff;

   sic_pkg::prod_type ab_ff, cd_ff, ef_ff, ag_ff, bf_ff, kg_ff;
   logic signed [sic_pkg::H_W-1:0] h_ff, n1_ff, n2_ff;

   sic_pkg::den_type    den4_ff, den5_ff, den_ff;
   sic_pkg::n1_type     n14_ff, n15_ff;
   sic_pkg::flags_type  fl4_ff, fl5_ff, fl_ff;

   sic_pkg::num_type mlx_ff, mkx_ff, mly_ff, mky_ff;
   sic_pkg::num_type numx_ff, numy_ff, numt_ff;

   logic signed [sic_pkg::H_W-1:0] h_in, n1_in, n2_in;
   sic_pkg::n1_type   hx_in, n1x_in, n2x_in, hn_in, n1n_in, n2n_in;
   sic_pkg::flags_type fl4_in;

   always_comb begin
      h_in   = sic_pkg::H_W'(ab_ff) - sic_pkg::H_W'(cd_ff);
      n1_in  = sic_pkg::H_W'(ef_ff) + sic_pkg::H_W'(ag_ff);
      n2_in  = sic_pkg::H_W'(bf_ff) + sic_pkg::H_W'(kg_ff);
      hx_in  = sic_pkg::N1_W'(h_ff);
      n1x_in = sic_pkg::N1_W'(n1_ff);
      n2x_in = sic_pkg::N1_W'(n2_ff);
      hn_in  = h_ff[sic_pkg::H_W-1] ? -hx_in  : hx_in;
      n1n_in = h_ff[sic_pkg::H_W-1] ? -n1x_in : n1x_in;
      n2n_in = h_ff[sic_pkg::H_W-1] ? -n2x_in : n2x_in;
      fl4_in.parallel = (h_ff == '0);
      fl4_in.hit = !fl4_in.parallel && !n1n_in[sic_pkg::N1_W-1] && (n1n_in <= hn_in)
                   && !n2n_in[sic_pkg::N1_W-1] && (n2n_in <= hn_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[sic_pkg::FRONT_LAT-2:0], in_valid};
      end

      a_ff   <= sic_pkg::DIFF_W'(rex) - sic_pkg::DIFF_W'(rsx);
      b_ff   <= sic_pkg::DIFF_W'(lsy) - sic_pkg::DIFF_W'(ley);
      c_ff   <= sic_pkg::DIFF_W'(lsx) - sic_pkg::DIFF_W'(lex);
      d_ff   <= sic_pkg::DIFF_W'(rey) - sic_pkg::DIFF_W'(rsy);
      e_ff   <= sic_pkg::DIFF_W'(rsy) - sic_pkg::DIFF_W'(rey);
      f_ff   <= sic_pkg::DIFF_W'(lsx) - sic_pkg::DIFF_W'(rsx);
      g_ff   <= sic_pkg::DIFF_W'(lsy) - sic_pkg::DIFF_W'(rsy);
      kx1_ff <= sic_pkg::DIFF_W'(lex) - sic_pkg::DIFF_W'(lsx);
      ky1_ff <= sic_pkg::DIFF_W'(ley) - sic_pkg::DIFF_W'(lsy);
      lsx1_ff <= lsx;
      lsy1_ff <= lsy;

      ab_ff <= sic_pkg::PROD_W'(a_ff) * sic_pkg::PROD_W'(b_ff);
      cd_ff <= sic_pkg::PROD_W'(c_ff) * sic_pkg::PROD_W'(d_ff);
      ef_ff <= sic_pkg::PROD_W'(e_ff) * sic_pkg::PROD_W'(f_ff);
      ag_ff <= sic_pkg::PROD_W'(a_ff) * sic_pkg::PROD_W'(g_ff);
      bf_ff <= sic_pkg::PROD_W'(b_ff) * sic_pkg::PROD_W'(f_ff);
      kg_ff <= sic_pkg::PROD_W'(kx1_ff) * sic_pkg::PROD_W'(g_ff);
      kx2_ff <= kx1_ff;
      ky2_ff <= ky1_ff;
      lsx2_ff <= lsx1_ff;
      lsy2_ff <= lsy1_ff;

      h_ff  <= h_in;
      n1_ff <= n1_in;
      n2_ff <= n2_in;
      kx3_ff <= kx2_ff;
      ky3_ff <= ky2_ff;
      lsx3_ff <= lsx2_ff;
      lsy3_ff <= lsy2_ff;

      den4_ff <= hn_in[sic_pkg::DEN_W-1:0];
      n14_ff  <= n1n_in;
      fl4_ff  <= fl4_in;
      kx4_ff  <= kx3_ff;
      ky4_ff  <= ky3_ff;
      lsx4_ff <= lsx3_ff;
      lsy4_ff <= lsy3_ff;

      mlx_ff <= sic_pkg::NUM_W'(lsx4_ff) * sic_pkg::NUM_W'({1'b0, den4_ff});
      mly_ff <= sic_pkg::NUM_W'(lsy4_ff) * sic_pkg::NUM_W'({1'b0, den4_ff});
      mkx_ff <= sic_pkg::NUM_W'(n14_ff) * sic_pkg::NUM_W'(kx4_ff);
      mky_ff <= sic_pkg::NUM_W'(n14_ff) * sic_pkg::NUM_W'(ky4_ff);
      den5_ff <= den4_ff;
      n15_ff  <= n14_ff;
      fl5_ff  <= fl4_ff;

      numx_ff <= mlx_ff + mkx_ff;
      numy_ff <= mly_ff + mky_ff;
      numt_ff <= sic_pkg::NUM_W'(n15_ff) <<< sic_pkg::FRAC_W;
      den_ff  <= den5_ff;
      fl_ff   <= fl5_ff;
   end

   assign out_valid = valid_ff[sic_pkg::FRONT_LAT-1];
   assign out_flags = fl_ff;
   assign num_x     = numx_ff;
   assign num_y     = numy_ff;
   assign num_t     = numt_ff;
   assign den       = den_ff;

endmodule

// ===== rtl/sic_div.sv =====
// Pipelined restoring divider of the segment intersection core, one quotient bit per stage,
// rounding to nearest with ties away from zero; overflow forces an all-ones quotient.
// Depends on sic_pkg.
module sic_div (
   input  logic              clock,
   input  sic_pkg::num_type  num,
   input  sic_pkg::den_type  den,
   output sic_pkg::quot_type quot,
   output logic              neg
);

   logic [sic_pkg::CMP_W-1:0] r_ff [0:sic_pkg::QB];
   logic [sic_pkg::QB-1:0]    q_ff [0:sic_pkg::QB];
   sic_pkg::den_type          d_ff [0:sic_pkg::QB];
   logic                      neg_ff [0:sic_pkg::QB];
   logic                      ovf_ff [0:sic_pkg::QB];

   logic [sic_pkg::CMP_W-1:0] r_in [0:sic_pkg::QB-1];
   logic                      b_in [0:sic_pkg::QB-1];
   logic [sic_pkg::NUM_W-1:0] mag_in;
   logic [sic_pkg::CMP_W-1:0] ds_in;
   logic                      rnd_in;

   sic_pkg::quot_type quot_ff;
   logic              negq_ff;

   always_comb begin
      mag_in = num[sic_pkg::NUM_W-1] ? (~num + 1'b1) : num;
      for (int s = 0; s < sic_pkg::QB; s++) begin
         ds_in   = sic_pkg::CMP_W'(d_ff[s]) << (sic_pkg::QB - 1 - s);
         b_in[s] = (r_ff[s] >= ds_in);
         r_in[s] = b_in[s] ? r_ff[s] - ds_in : r_ff[s];
      end
      rnd_in = ((r_ff[sic_pkg::QB] << 1) >= sic_pkg::CMP_W'(d_ff[sic_pkg::QB]));
   end

   always_ff @(posedge clock) begin
      r_ff[0]   <= sic_pkg::CMP_W'(mag_in);
      q_ff[0]   <= '0;
      d_ff[0]   <= den;
      neg_ff[0] <= num[sic_pkg::NUM_W-1];
      ovf_ff[0] <= (sic_pkg::CMP_W'(mag_in) >= (sic_pkg::CMP_W'(den) << sic_pkg::QB));
      for (int s = 0; s < sic_pkg::QB; s++) begin
         r_ff[s+1]   <= r_in[s];
         q_ff[s+1]   <= {q_ff[s][sic_pkg::QB-2:0], b_in[s]};
         d_ff[s+1]   <= d_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
      end
      quot_ff <= ovf_ff[sic_pkg::QB] ? '1
                 : {1'b0, q_ff[sic_pkg::QB]} + sic_pkg::quot_type'(rnd_in);
      negq_ff <= neg_ff[sic_pkg::QB];
   end

   assign quot = quot_ff;
   assign neg  = negq_ff;

endmodule

// ===== rtl/segment_intersection_core.sv =====
// Top level of the segment intersection core.
// Depends on sic_pkg, sic_front and sic_div.
//
// Usage: drive the eight coordinates of a segment and a ray segment on the req_ ports
// and raise start. A transfer takes place at every rising edge with start high; busy is
// always low, so a new test may start in every cycle. Each test gives exactly one
// result on the rsp_ ports, marked by rsp_valid for one cycle, in order of entry.
// From the start edge to the edge that takes the result: six front stages (differences,
// cross products, sign normalization with hit test, dividend products and sums), 35
// stages in each of the three parallel dividers (input, one per quotient bit, rounding),
// and one saturation stage. Throughput is one test per cycle.
// A zero denominator reports rsp_parallel with no hit and zero point and parameter.
// Synchronous reset clears all valid bits; tests in flight are dropped. The receiver
// cannot stall, so results are presented exactly once and never held.
module segment_intersection_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  sic_pkg::coord_type        req_line_start_x,
   input  sic_pkg::coord_type        req_line_start_y,
   input  sic_pkg::coord_type        req_line_end_x,
   input  sic_pkg::coord_type        req_line_end_y,
   input  sic_pkg::coord_type        req_ray_start_x,
   input  sic_pkg::coord_type        req_ray_start_y,
   input  sic_pkg::coord_type        req_ray_end_x,
   input  sic_pkg::coord_type        req_ray_end_y,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic                      rsp_parallel,
   output sic_pkg::coord_type        rsp_cross_x,
   output sic_pkg::coord_type        rsp_cross_y,
   output logic signed [sic_pkg::PARAM_W-1:0] rsp_seg_param
);

   logic               f_valid;
   sic_pkg::flags_type f_flags;
   sic_pkg::num_type   num_x, num_y, num_t;
   sic_pkg::den_type   den;
   sic_pkg::quot_type  qx, qy, qt;
   logic               nx, ny, nt;

   logic [sic_pkg::DIV_LAT-1:0] dv_ff;
   sic_pkg::flags_type          dfl_ff [0:sic_pkg::DIV_LAT-1];

   logic                             valid_ff, hit_ff, par_ff;
   logic [sic_pkg::COORD_W-1:0]      cx_ff, cy_ff;
   logic [sic_pkg::PARAM_W-1:0]      tp_ff;

   assign busy = 1'b0;

   sic_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .lsx       (req_line_start_x),
      .lsy       (req_line_start_y),
      .lex       (req_line_end_x),
      .ley       (req_line_end_y),
      .rsx       (req_ray_start_x),
      .rsy       (req_ray_start_y),
      .rex       (req_ray_end_x),
      .rey       (req_ray_end_y),
      .out_valid (f_valid),
      .out_flags (f_flags),
      .num_x     (num_x),
      .num_y     (num_y),
      .num_t     (num_t),
      .den       (den)
   );

   sic_div u_div_x (.clock(clock), .num(num_x), .den(den), .quot(qx), .neg(nx));
   sic_div u_div_y (.clock(clock), .num(num_y), .den(den), .quot(qy), .neg(ny));
   sic_div u_div_t (.clock(clock), .num(num_t), .den(den), .quot(qt), .neg(nt));

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         dv_ff    <= {dv_ff[sic_pkg::DIV_LAT-2:0], f_valid};
         valid_ff <= dv_ff[sic_pkg::DIV_LAT-1];
      end
      dfl_ff[0] <= f_flags;
      for (int s = 1; s < sic_pkg::DIV_LAT; s++) begin
         dfl_ff[s] <= dfl_ff[s-1];
      end
      hit_ff <= dfl_ff[sic_pkg::DIV_LAT-1].hit;
      par_ff <= dfl_ff[sic_pkg::DIV_LAT-1].parallel;
      if (dfl_ff[sic_pkg::DIV_LAT-1].parallel) begin
         cx_ff <= '0;
         cy_ff <= '0;
         tp_ff <= '0;
      end else begin
         cx_ff <= sic_pkg::sat_coord(qx, nx);
         cy_ff <= sic_pkg::sat_coord(qy, ny);
         tp_ff <= sic_pkg::sat_param(qt, nt);
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_parallel  = par_ff;
   assign rsp_cross_x   = cx_ff;
   assign rsp_cross_y   = cy_ff;
   assign rsp_seg_param = tp_ff;

   a_no_hit_when_parallel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel |-> !rsp_hit)
      else $error("hit reported with zero denominator");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel |-> rsp_cross_x == '0 && rsp_cross_y == '0
                                    && rsp_seg_param == '0)
      else $error("nonzero result with zero denominator");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, sic_pkg::TOTAL_LAT))
      else $error("result without a matching start transfer");

endmodule
